// ===== hdl/pcfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_pkg
// Shared constants, types and helpers of the per-channel fused activation block.
// ----------------------------------------------------------------------------
package pcfa_pkg;

  localparam int unsigned MaxChannels = 1024;
  localparam int unsigned FracBits    = 16;

  localparam int unsigned ChanW     = (MaxChannels > 1) ? $clog2(MaxChannels) : 1;
  localparam int unsigned CntW      = ChanW + 1;
  localparam int unsigned CoefWords = 4;
  localparam int unsigned QW        = 32;
  localparam int unsigned MulW      = QW + 1;
  localparam int unsigned ProdW     = 2 * MulW;
  localparam int unsigned AccW      = ProdW + 2;
  localparam int unsigned PosW      = 16;
  localparam int unsigned SizeW     = PosW + 1;
  localparam int unsigned SizeMax   = 65536;
  localparam int unsigned CntCfgW   = 11;
  localparam int unsigned CfgIdxW   = 2;
  localparam int unsigned CfgDataW  = 32;
  localparam int unsigned ChIdxW    = 10;
  localparam int unsigned WordIdxW  = 2;

  typedef enum logic [2:0] {
    MODE_ABSSCALE = 3'd0,
    MODE_NEGSCALE = 3'd1,
    MODE_AFFINE   = 3'd2,
    MODE_PRELU    = 3'd3,
    MODE_DUALRELU = 3'd4,
    MODE_HSWISH   = 3'd5
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MODE          = 2'd0,
    CFG_CHANNEL_LAST  = 2'd1,
    CFG_CHANNEL_COUNT = 2'd2,
    CFG_SPATIAL_SIZE  = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    OP_DATA = 1'b0,
    OP_COEF = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_POST
  } state_e;

  // saturate a wide signed sum to the q range
  function automatic logic signed [QW-1:0] sat_q(input logic signed [AccW-1:0] v);
    logic [AccW-QW:0] top;
    top = v[AccW-1:QW-1];
    if (top == '0 || top == '1) begin
      sat_q = v[QW-1:0];
    end else if (v[AccW-1]) begin
      sat_q = {1'b1, {(QW-1){1'b0}}};
    end else begin
      sat_q = {1'b0, {(QW-1){1'b1}}};
    end
  endfunction

endpackage

// ===== hdl/pcfa_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_in_if
// Input channel: tensor elements and coefficient table writes.
// ----------------------------------------------------------------------------
interface pcfa_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   op;
  logic signed [pcfa_pkg::QW-1:0]         value;
  logic        [pcfa_pkg::ChIdxW-1:0]     channel_index;
  logic        [pcfa_pkg::WordIdxW-1:0]   word_index;

  modport source (output valid, output op, output value, output channel_index,
                  output word_index, input ready);
  modport sink   (input valid, input op, input value, input channel_index,
                  input word_index, output ready);
endinterface

// ===== hdl/pcfa_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_out_if
// Output channel: activation results.
// ----------------------------------------------------------------------------
interface pcfa_out_if;
  logic                           valid;
  logic                           ready;
  logic signed [pcfa_pkg::QW-1:0] result_value;
  logic                           second_output;
  logic                           last_of_run;

  modport source (output valid, output result_value, output second_output,
                  output last_of_run, input ready);
  modport sink   (input valid, input result_value, input second_output,
                  input last_of_run, output ready);
endinterface

// ===== hdl/pcfa_cfg_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface pcfa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pcfa_pkg::CfgIdxW-1:0]      index;
  logic [pcfa_pkg::CfgDataW-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hdl/pcfa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module pcfa_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/per_channel_fused_activation_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_channel_fused_activation_top
// Per-channel fused bias/scale/activation on a stream of Q16.16 elements.
// ----------------------------------------------------------------------------
// A tensor element passes four steps (accept, coefficient table read,
// multiply, post-add and saturate); modes affine leaky and hard swish repeat
// the multiply and post-add steps, as they run the shared 33x33 multiplier
// twice. The coefficient table is four 1024-entry RAM banks read at the current
// channel, so elements are processed one at a time. Results go to an output
// register, with a second slot for the dual-relu second result, so the next
// element is accepted while a result still waits; a stalled output holds the
// post stage of the following element.
module per_channel_fused_activation_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  pcfa_in_if.sink    in_i,
  pcfa_out_if.source out_o,
  pcfa_cfg_if.sink   cfg_i
);

  localparam int unsigned ChanW = pcfa_pkg::ChanW;
  localparam int unsigned CntW  = pcfa_pkg::CntW;
  localparam int unsigned QW    = pcfa_pkg::QW;
  localparam int unsigned MulW  = pcfa_pkg::MulW;
  localparam int unsigned ProdW = pcfa_pkg::ProdW;
  localparam int unsigned AccW  = pcfa_pkg::AccW;
  localparam int unsigned PosW  = pcfa_pkg::PosW;
  localparam int unsigned SizeW = pcfa_pkg::SizeW;
  localparam int unsigned FracB = pcfa_pkg::FracBits;

  // configuration
  pcfa_pkg::mode_e             mode_q;
  logic                        chlast_q;
  logic [pcfa_pkg::CntCfgW-1:0] chcnt_q;
  logic [SizeW-1:0]            spsize_q;

  // channel tracking
  logic [ChanW-1:0] ch_q, ch_d;
  logic [PosW-1:0]  pos_q, pos_d;

  // sequencer
  pcfa_pkg::state_e state_q, state_d;
  logic             pass_q, pass_d;

  // datapath registers
  logic signed [QW-1:0]    v_q;
  logic signed [QW-1:0]    x_q, x_d;
  logic signed [ProdW-1:0] prod_q, prod_d;

  // output stage
  logic                 ov_q, ov_d;
  logic signed [QW-1:0] oval_q, oval_d;
  logic                 osec_q, osec_d;
  logic                 olast_q, olast_d;
  logic                 pend2_q, pend2_d;
  logic signed [QW-1:0] y2_q, y2_d;

  // control
  logic in_ready, x_load, prod_load, x_reload, post_load;
  logic in_acc, data_acc, coef_acc, out_free;

  // ram
  logic [QW-1:0] rdata [pcfa_pkg::CoefWords];
  logic          coef_ok;

  assign in_acc   = in_i.valid && in_ready;
  assign data_acc = in_acc && (pcfa_pkg::op_e'(in_i.op) == pcfa_pkg::OP_DATA);
  assign coef_acc = in_acc && (pcfa_pkg::op_e'(in_i.op) == pcfa_pkg::OP_COEF);
  assign coef_ok  = (32'(in_i.channel_index) < pcfa_pkg::MaxChannels);
  assign out_free = !ov_q || out_o.ready;

  for (genvar k = 0; k < pcfa_pkg::CoefWords; k++) begin : g_bank
    pcfa_ram #(
      .Width (QW),
      .Depth (pcfa_pkg::MaxChannels)
    ) u_bank (
      .clk_i   (clk_i),
      .we_i    (coef_acc && coef_ok &&
                (in_i.word_index == pcfa_pkg::WordIdxW'(k))),
      .waddr_i (ChanW'(in_i.channel_index)),
      .wdata_i (in_i.value),
      .re_i    (data_acc),
      .raddr_i (ch_q),
      .rdata_o (rdata[k])
    );
  end

  logic signed [QW-1:0] w0, w1, w2, w3;
  assign w0 = rdata[0];
  assign w1 = rdata[1];
  assign w2 = rdata[2];
  assign w3 = rdata[3];

  // ---------------- configuration ----------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= pcfa_pkg::MODE_ABSSCALE;
      chlast_q <= 1'b0;
      chcnt_q  <= pcfa_pkg::CntCfgW'(1);
      spsize_q <= SizeW'(1);
    end else if (cfg_i.valid) begin
      unique case (pcfa_pkg::cfg_reg_e'(cfg_i.index))
        pcfa_pkg::CFG_MODE:          mode_q   <= pcfa_pkg::mode_e'(cfg_i.data[2:0]);
        pcfa_pkg::CFG_CHANNEL_LAST:  chlast_q <= cfg_i.data[0];
        pcfa_pkg::CFG_CHANNEL_COUNT: chcnt_q  <= cfg_i.data[pcfa_pkg::CntCfgW-1:0];
        pcfa_pkg::CFG_SPATIAL_SIZE:  spsize_q <= cfg_i.data[SizeW-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- channel counter ----------------
  logic [CntW-1:0]  cnt_eff;
  logic [SizeW-1:0] sz_eff;

  always_comb begin
    if (chcnt_q == '0) begin
      cnt_eff = CntW'(1);
    end else if (32'(chcnt_q) > pcfa_pkg::MaxChannels) begin
      cnt_eff = CntW'(pcfa_pkg::MaxChannels);
    end else begin
      cnt_eff = CntW'(chcnt_q);
    end
    if (spsize_q == '0) begin
      sz_eff = SizeW'(1);
    end else if (32'(spsize_q) > pcfa_pkg::SizeMax) begin
      sz_eff = SizeW'(pcfa_pkg::SizeMax);
    end else begin
      sz_eff = spsize_q;
    end
  end

  always_comb begin
    ch_d  = ch_q;
    pos_d = pos_q;
    if (data_acc) begin
      if (!chlast_q && ((SizeW'(pos_q) + SizeW'(1)) < sz_eff)) begin
        pos_d = pos_q + PosW'(1);
      end else begin
        if (!chlast_q) begin
          pos_d = '0;
        end
        if ((CntW'(ch_q) + CntW'(1)) < cnt_eff) begin
          ch_d = ch_q + ChanW'(1);
        end else begin
          ch_d = '0;
        end
      end
    end
  end

  // ---------------- datapath ----------------
  logic signed [MulW-1:0] x_ext, x_pos, x_neg, k_ext, ma, mb;
  logic signed [QW-1:0]   x_first, min_x_w2, k_val;
  logic signed [ProdW-1:0] p_f, p_f1;
  logic signed [QW-1:0]   y1, y2;
  logic                   fin, dual;

  // biased element, taken into x in the read cycle
  assign x_first  = pcfa_pkg::sat_q(AccW'(v_q) + AccW'(w0));
  assign x_ext    = MulW'(x_q);
  assign x_pos    = x_q[QW-1] ? '0 : x_ext;
  assign x_neg    = x_q[QW-1] ? x_ext : '0;
  assign min_x_w2 = (x_q < w2) ? x_q : w2;
  assign k_val    = (w1 > min_x_w2) ? w1 : min_x_w2;
  assign k_ext    = MulW'(k_val);
  assign p_f      = prod_q >>> FracB;
  assign p_f1     = prod_q >>> (FracB - 1);

  // multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (mode_q)
      pcfa_pkg::MODE_ABSSCALE: begin ma = x_neg; mb = MulW'(w1); end
      pcfa_pkg::MODE_NEGSCALE: begin ma = -x_neg; mb = MulW'(w1); end
      pcfa_pkg::MODE_AFFINE: begin
        if (pass_q) begin ma = x_neg; mb = MulW'(w2); end
        else begin ma = MulW'(v_q); mb = MulW'(w0); end
      end
      pcfa_pkg::MODE_PRELU:    begin ma = x_neg; mb = MulW'(w1); end
      pcfa_pkg::MODE_DUALRELU: begin ma = x_ext; mb = MulW'(w1); end
      pcfa_pkg::MODE_HSWISH: begin
        if (pass_q) begin ma = x_ext; mb = MulW'(v_q); end
        else begin ma = k_ext; mb = MulW'(w3); end
      end
      default: ;
    endcase
    prod_d = ma * mb;
  end

  // post-add, saturation, and second-pass operand
  always_comb begin
    fin  = 1'b1;
    dual = 1'b0;
    y1   = '0;
    y2   = '0;
    x_d  = x_first;
    unique case (mode_q)
      pcfa_pkg::MODE_ABSSCALE: y1 = pcfa_pkg::sat_q(AccW'(p_f1) + AccW'(x_pos));
      pcfa_pkg::MODE_NEGSCALE:
        y1 = pcfa_pkg::sat_q(AccW'(p_f) + AccW'(w2) + AccW'(x_pos));
      pcfa_pkg::MODE_AFFINE: begin
        if (pass_q) begin
          y1 = pcfa_pkg::sat_q(AccW'(x_pos) + AccW'(p_f));
        end else begin
          fin = 1'b0;
          x_d = pcfa_pkg::sat_q(AccW'(p_f) + AccW'(w1));
        end
      end
      pcfa_pkg::MODE_PRELU: y1 = pcfa_pkg::sat_q(AccW'(x_pos) + AccW'(p_f));
      pcfa_pkg::MODE_DUALRELU: begin
        dual = 1'b1;
        y1   = x_pos[QW-1:0];
        y2   = pcfa_pkg::sat_q(AccW'(p_f) + AccW'(w2));
        if (y2[QW-1]) begin
          y2 = '0;
        end
      end
      pcfa_pkg::MODE_HSWISH: begin
        if (pass_q) begin
          y1 = pcfa_pkg::sat_q(AccW'(p_f));
        end else begin
          fin = 1'b0;
          x_d = pcfa_pkg::sat_q(AccW'(p_f));
        end
      end
      default: ;
    endcase
  end

  // ---------------- sequencer ----------------
  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    unique case (state_q)
      pcfa_pkg::ST_IDLE: begin
        if (data_acc) begin
          state_d = pcfa_pkg::ST_READ;
          pass_d  = 1'b0;
        end
      end
      pcfa_pkg::ST_READ: state_d = pcfa_pkg::ST_MUL;
      pcfa_pkg::ST_MUL:  state_d = pcfa_pkg::ST_POST;
      pcfa_pkg::ST_POST: begin
        if (!fin) begin
          state_d = pcfa_pkg::ST_MUL;
          pass_d  = 1'b1;
        end else if (out_free && !pend2_q) begin
          state_d = pcfa_pkg::ST_IDLE;
        end
      end
      default: state_d = pcfa_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    x_load    = 1'b0;
    prod_load = 1'b0;
    x_reload  = 1'b0;
    post_load = 1'b0;
    unique case (state_q)
      pcfa_pkg::ST_IDLE: in_ready  = 1'b1;
      pcfa_pkg::ST_READ: x_load    = 1'b1;
      pcfa_pkg::ST_MUL:  prod_load = 1'b1;
      pcfa_pkg::ST_POST: begin
        x_reload  = !fin;
        post_load = fin && out_free && !pend2_q;
      end
      default: ;
    endcase
  end

  assign in_i.ready = in_ready;

  // ---------------- output stage ----------------
  always_comb begin
    ov_d    = ov_q;
    oval_d  = oval_q;
    osec_d  = osec_q;
    olast_d = olast_q;
    pend2_d = pend2_q;
    y2_d    = y2_q;
    if (out_free) begin
      if (pend2_q) begin
        ov_d    = 1'b1;
        oval_d  = y2_q;
        osec_d  = 1'b1;
        olast_d = 1'b1;
        pend2_d = 1'b0;
      end else if (post_load) begin
        ov_d    = 1'b1;
        oval_d  = y1;
        osec_d  = 1'b0;
        olast_d = !dual;
        pend2_d = dual;
        y2_d    = y2;
      end else begin
        ov_d = 1'b0;
      end
    end
  end

  assign out_o.valid         = ov_q;
  assign out_o.result_value  = oval_q;
  assign out_o.second_output = osec_q;
  assign out_o.last_of_run   = olast_q;

  // ---------------- registers ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pcfa_pkg::ST_IDLE;
      pass_q  <= 1'b0;
      ch_q    <= '0;
      pos_q   <= '0;
      ov_q    <= 1'b0;
      pend2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      ch_q    <= ch_d;
      pos_q   <= pos_d;
      ov_q    <= ov_d;
      pend2_q <= pend2_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (data_acc) begin
      v_q <= in_i.value;
    end
    if (x_load) begin
      x_q <= x_first;
    end else if (x_reload) begin
      x_q <= x_d;
    end
    if (prod_load) begin
      prod_q <= prod_d;
    end
    oval_q  <= oval_d;
    osec_q  <= osec_d;
    olast_q <= olast_d;
    y2_q    <= y2_d;
  end

endmodule

// ===== bench/pcfa_act_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pcfa_act_checker
// Watches the input, result and register channels of the fused activation
// block, keeps its own coefficient table, configuration and channel counter,
// predicts the results of every element and compares them in order.
// ----------------------------------------------------------------------------
module pcfa_act_checker
  import pcfa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  pcfa_in_if   in_i,
  pcfa_out_if  out_i,
  pcfa_cfg_if  cfg_i,
  output int   mismatches_o,
  output int   pending_o,
  output int   checked_o
);

  typedef struct packed {
    logic signed [QW-1:0] value;
    logic                 second;
    logic                 last;
  } act_result_t;

  localparam longint QMax = 64'sd2147483647;
  localparam longint QMin = -64'sd2147483648;

  logic signed [QW-1:0] coef_mem [CoefWords*MaxChannels];
  logic [2:0]           mode_q;
  logic                 chan_last_q;
  logic [CntCfgW-1:0]   chan_count_q;
  logic [SizeW-1:0]     plane_size_q;
  int unsigned          chan_q;
  int unsigned          plane_pos_q;
  int                   err_cnt;
  int                   match_cnt;
  act_result_t          act_results_q[$];

  function automatic longint clamp_q(input longint v);
    return (v > QMax) ? QMax : ((v < QMin) ? QMin : v);
  endfunction

  // exact product, low bits dropped (floor)
  function automatic longint fx_mul(input longint a, input longint b,
                                    input int unsigned shift);
    return (a * b) >>> shift;
  endfunction

  function automatic longint pos_part(input longint v);
    return (v > 0) ? v : 0;
  endfunction

  function automatic longint neg_part(input longint v);
    return (v < 0) ? v : 0;
  endfunction

  function automatic void predict_element(input logic signed [QW-1:0] elem);
    longint      v, x, w0, w1, w2, w3, k, q, y, y2;
    int unsigned base, cnt, sz;
    base = chan_q * CoefWords;
    v  = elem;
    w0 = coef_mem[base];
    w1 = coef_mem[base + 1];
    w2 = coef_mem[base + 2];
    w3 = coef_mem[base + 3];
    x  = clamp_q(v + w0);
    y2 = 0;
    case (mode_q)
      MODE_ABSSCALE: y = clamp_q(fx_mul(neg_part(x), w1, FracBits - 1) + pos_part(x));
      MODE_NEGSCALE: y = clamp_q(fx_mul(pos_part(-x), w1, FracBits) + w2 + pos_part(x));
      MODE_AFFINE: begin
        x = clamp_q(fx_mul(v, w0, FracBits) + w1);
        y = clamp_q(pos_part(x) + fx_mul(neg_part(x), w2, FracBits));
      end
      MODE_PRELU: y = clamp_q(pos_part(x) + fx_mul(neg_part(x), w1, FracBits));
      MODE_DUALRELU: begin
        y  = pos_part(x);
        y2 = pos_part(clamp_q(fx_mul(x, w1, FracBits) + w2));
      end
      MODE_HSWISH: begin
        k = (x < w2) ? x : w2;
        if (w1 > k) k = w1;
        q = clamp_q(fx_mul(k, w3, FracBits));
        y = clamp_q(fx_mul(q, v, FracBits));
      end
      default: y = 0;
    endcase

    if (mode_q == MODE_DUALRELU) begin
      act_results_q.push_back('{value: y[QW-1:0], second: 1'b0, last: 1'b0});
      act_results_q.push_back('{value: y2[QW-1:0], second: 1'b1, last: 1'b1});
    end else begin
      act_results_q.push_back('{value: y[QW-1:0], second: 1'b0, last: 1'b1});
    end

    // channel counter, with out-of-range settings clamped
    cnt = (chan_count_q == 0) ? 1 : ((chan_count_q > MaxChannels) ? MaxChannels : chan_count_q);
    sz  = (plane_size_q == 0) ? 1 : ((plane_size_q > SizeMax) ? SizeMax : plane_size_q);
    if (!chan_last_q) begin
      if (plane_pos_q + 1 < sz) begin
        plane_pos_q++;
        return;
      end
      plane_pos_q = 0;
    end
    chan_q = (chan_q + 1 < cnt) ? chan_q + 1 : 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    act_result_t want;
    if (!rst_ni) begin
      mode_q       = MODE_ABSSCALE;
      chan_last_q  = 1'b0;
      chan_count_q = 1;
      plane_size_q = 1;
      chan_q       = 0;
      plane_pos_q  = 0;
      err_cnt      = 0;
      match_cnt    = 0;
      act_results_q.delete();
      mismatches_o <= 0;
      pending_o    <= 0;
      checked_o    <= 0;
    end else begin
      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          CFG_MODE:          mode_q       = cfg_i.data[2:0];
          CFG_CHANNEL_LAST:  chan_last_q  = cfg_i.data[0];
          CFG_CHANNEL_COUNT: chan_count_q = cfg_i.data[CntCfgW-1:0];
          CFG_SPATIAL_SIZE:  plane_size_q = cfg_i.data[SizeW-1:0];
          default: ;
        endcase
      end

      if (in_i.valid && in_i.ready) begin
        if (in_i.op == OP_COEF) begin
          coef_mem[{in_i.channel_index, in_i.word_index}] = in_i.value;
        end else begin
          predict_element(in_i.value);
        end
      end

      if (out_i.valid && out_i.ready) begin
        if (act_results_q.size() == 0) begin
          $display("%0t: unexpected result, value %0d second %0b last %0b", $time,
                   out_i.result_value, out_i.second_output, out_i.last_of_run);
          err_cnt++;
        end else begin
          want = act_results_q.pop_front();
          match_cnt++;
          if (out_i.result_value !== want.value) begin
            $display("%0t: result_value expected %0d (%h) got %0d (%h)", $time,
                     $signed(want.value), want.value, out_i.result_value,
                     out_i.result_value);
            err_cnt++;
          end
          if (out_i.second_output !== want.second) begin
            $display("%0t: second_output expected %0b got %0b", $time, want.second,
                     out_i.second_output);
            err_cnt++;
          end
          if (out_i.last_of_run !== want.last) begin
            $display("%0t: last_of_run expected %0b got %0b", $time, want.last,
                     out_i.last_of_run);
            err_cnt++;
          end
        end
      end

      mismatches_o <= err_cnt;
      pending_o    <= act_results_q.size();
      checked_o    <= match_cnt;
    end
  end

endmodule

// ===== bench/per_channel_fused_activation_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// per_channel_fused_activation_top_tb
// Loads the coefficients of every channel the counter can reach, runs a short
// set of saturating cases in every mode, then random element streams under
// many register setups and handshake idle patterns, and reports the verdict.
// ----------------------------------------------------------------------------
module per_channel_fused_activation_top_tb;
  import pcfa_pkg::*;

  localparam int unsigned PhaseCount    = 16;
  localparam int unsigned ItemsPerPhase = 42;
  // the counter moves one channel per element at most, and every few phases
  // a count of one brings it back to zero, so it stays well below this
  localparam int unsigned LoadChannels  = 128;
  localparam int unsigned SettleCycles  = 12;
  localparam int unsigned QuietLimit    = 5000;
  localparam int unsigned SmallSpan     = 4 << FracBits;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned elem_cnt = 0;
  int unsigned coef_cnt = 0;
  int unsigned setup_cnt = 0;
  int unsigned quiet_cycles = 0;
  int          mismatches;
  int          pending;
  int          checked;

  pcfa_in_if  in_ch ();
  pcfa_out_if out_ch ();
  pcfa_cfg_if cfg_ch ();

  per_channel_fused_activation_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  pcfa_act_checker act_chk (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_ch),
    .out_i        (out_ch),
    .cfg_i        (cfg_ch),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  always #5 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
      $display("per_channel_fused_activation_top_tb: errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // mostly small q values, some full-range words and some extremes
  function automatic logic [QW-1:0] rand_q_word();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      case ($urandom_range(5))
        0: return 32'h8000_0000;
        1: return 32'h7FFF_FFFF;
        2: return 32'h0000_0000;
        3: return 32'hFFFF_FFFF;
        4: return 32'h0001_0000;
        default: return 32'hFFFF_0000;
      endcase
    end
    if (sel < 35) return $urandom;
    return $urandom_range(0, 2 * SmallSpan) - SmallSpan;
  endfunction

  // random bits above the register's width
  function automatic logic [CfgDataW-1:0] with_junk(input logic [CfgDataW-1:0] val,
                                                    input int unsigned width);
    return ($urandom << width) | val;
  endfunction

  task automatic send_item(input op_e op, input logic [QW-1:0] value,
                           input logic [ChIdxW-1:0] ch, input logic [WordIdxW-1:0] word);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid         <= 1'b1;
    in_ch.op            <= op;
    in_ch.value         <= value;
    in_ch.channel_index <= ch;
    in_ch.word_index    <= word;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    if (op == OP_COEF) coef_cnt++;
    else elem_cnt++;
  endtask

  task automatic send_element(input logic [QW-1:0] value);
    send_item(OP_DATA, value, ChIdxW'($urandom), WordIdxW'($urandom));
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // stop sending, let every result arrive, then give the pipe time to empty
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic apply_setup(input logic [2:0] mode, input logic chan_last,
                             input int unsigned count, input int unsigned size);
    drain();
    write_reg(CFG_MODE, with_junk(32'(mode), 3));
    write_reg(CFG_CHANNEL_LAST, with_junk(32'(chan_last), 1));
    write_reg(CFG_CHANNEL_COUNT, with_junk(count, CntCfgW));
    write_reg(CFG_SPATIAL_SIZE, with_junk(size, SizeW));
    setup_cnt++;
  endtask

  initial begin
    int unsigned ch, w, m, p, i, cnt, sz;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.op            = OP_DATA;
    in_ch.value         = '0;
    in_ch.channel_index = '0;
    in_ch.word_index    = '0;
    cfg_ch.valid        = 1'b0;
    cfg_ch.index        = CFG_MODE;
    cfg_ch.data         = '0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // every reachable coefficient written before any element can read it
    for (ch = 0; ch < LoadChannels; ch++) begin
      for (w = 0; w < CoefWords; w++) begin
        send_item(OP_COEF, rand_q_word(), ChIdxW'(ch), WordIdxW'(w));
      end
    end

    // saturating coefficients on channel 0, extreme elements in every mode code
    send_item(OP_COEF, 32'h0000_0000, '0, 2'd0);
    send_item(OP_COEF, 32'h7FFF_FFFF, '0, 2'd1);
    send_item(OP_COEF, 32'h8000_0000, '0, 2'd2);
    send_item(OP_COEF, 32'h7FFF_FFFF, '0, 2'd3);
    for (m = 0; m < 8; m++) begin
      apply_setup(3'(m), 1'b0, 1, 1);
      send_element(32'h8000_0000);
      send_element(32'h7FFF_FFFF);
      if (m <= MODE_HSWISH) send_element(32'hFFFF_FFFF);
    end

    for (p = 0; p < PhaseCount; p++) begin
      case (p % 6)
        0: cnt = 1;
        1: cnt = 0;
        2: cnt = MaxChannels;
        3: cnt = 2047;
        4: cnt = $urandom_range(2, 8);
        default: cnt = $urandom_range(9, MaxChannels - 1);
      endcase
      case (p % 5)
        0: sz = 1;
        1: sz = 0;
        2: sz = SizeMax;
        3: sz = 131071;
        default: sz = $urandom_range(2, 6);
      endcase
      apply_setup(3'(p % 8), 1'((p / 2) % 2), cnt, sz);
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
        default: begin send_idle_pct = 19; recv_stall_pct = 19; end
      endcase
      for (i = 0; i < ItemsPerPhase; i++) begin
        if (i == ItemsPerPhase / 2) drain();
        if ($urandom_range(9) == 0) begin
          send_item(OP_COEF, rand_q_word(), ChIdxW'($urandom), WordIdxW'($urandom));
        end else begin
          send_element(rand_q_word());
        end
      end
    end

    drain();
    $display("sent %0d elements and %0d coefficient words under %0d register setups",
             elem_cnt, coef_cnt, setup_cnt);
    $display("checked %0d results across all mode codes, both layouts, count/size extremes",
             checked);
    if (mismatches == 0 && pending == 0) begin
      $display("per_channel_fused_activation_top_tb: clean");
    end else begin
      $display("per_channel_fused_activation_top_tb: errors");
    end
    $finish;
  end

endmodule
